// File: sv/thpq_pkg.sv
// Shared types, codes and helpers for the ternary heap priority queue.
package thpq_pkg;

  // Request codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Field widths
  localparam int KEY_W = 32;
  localparam int OCC_W = 9;

  // Reciprocal of three for 16-bit operands: x/3 == (x * 0xAAAB) >> 17
  localparam logic [16:0] RECIP3     = 17'h0AAAB;
  localparam int          RECIP3_SHR = 17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_FIN,
    S_RD_TOP,
    S_RD_LAST,
    S_DN_START,
    S_DN_CH,
    S_DONE
  } thpq_state_t;

  // Parent slot number: floor(x / 3) for x below 2^16
  function automatic logic [15:0] div3(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * {16'd0, RECIP3};
    return prod[RECIP3_SHR +: 16];
  endfunction

endpackage

// File: sv/thpq_if.sv
// Channel interfaces: request, result and configuration write.
interface thpq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [thpq_pkg::KEY_W-1:0] key_value;
  modport source(output valid, output opcode, output key_value, input ready);
  modport sink(input valid, input opcode, input key_value, output ready);
endinterface

interface thpq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [thpq_pkg::KEY_W-1:0] top_value;
  logic [1:0]                        status;
  logic [thpq_pkg::OCC_W-1:0]        occupancy;
  modport source(output valid, output top_value, output status, output occupancy,
                 input ready);
  modport sink(input valid, input top_value, input status, input occupancy,
               output ready);
endinterface

interface thpq_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;
  modport source(output valid, output order_mode, input ready);
  modport sink(input valid, input order_mode, output ready);
endinterface

// File: sv/ternary_heap_priority_queue.sv
// Top level: 3-ary heap priority queue with a one-port-pair key memory.
//
// The keys live in one synchronous RAM of CAPACITY words (one write, one
// registered read per cycle), sifted by a small sequencer that carries the
// moving key in a register and writes each displaced key once. One request
// is handled at a time. A peek reads the root only; an insert reads one
// parent per level the key climbs (one RAM read per level), or writes the
// root directly into an empty heap; a remove reads the last key and then,
// per level it descends, reads up to three children and makes a decision,
// or skips the sift when it takes the last key. Full, empty and unused-code
// requests go straight to the result. The result sits in an output
// register, so the next request is taken while it waits. No clearing pass
// runs after reset; only slots below the entry count are ever used. Order
// mode is a single register; the user must write it only between requests,
// as the block itself does not enforce it; cfg ready is always high.
module ternary_heap_priority_queue #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  thpq_in_if.sink            in_ch,
  thpq_out_if.source         out_ch,
  thpq_cfg_if.sink           cfg_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = AW + 2;
  localparam int KW = thpq_pkg::KEY_W;

  // Strict rank compare under the current order
  function automatic logic ranks_ahead(input logic signed [KW-1:0] a,
                                       input logic signed [KW-1:0] b,
                                       input logic mode);
    logic res;
    res = mode ? (a < b) : (a > b);
    return res;
  endfunction

  thpq_pkg::thpq_state_t state_r, state_nxt;

  logic [1:0]           op_r, op_nxt;
  logic signed [KW-1:0] key_r, key_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        parent_r, parent_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [FW-1:0]        first_r, first_nxt;
  logic [1:0]           csel_r, csel_nxt;
  logic signed [KW-1:0] best_r, best_nxt;
  logic [AW-1:0]        best_idx_r, best_idx_nxt;
  logic signed [KW-1:0] top_r, top_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 order_mode_r;

  logic                                out_valid_r;
  logic signed [KW-1:0]                out_top_r;
  logic [1:0]                          out_status_r;
  logic [thpq_pkg::OCC_W-1:0]          out_occ_r;

  // Key memory ports
  logic signed [KW-1:0] heap_mem [CAPACITY];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [KW-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic signed [KW-1:0] mem_rdata;

  // Decision terms
  logic                 in_xfer;
  logic                 out_free;
  logic                 is_full;
  logic                 is_empty;
  logic [AW-1:0]        new_parent;
  logic                 up_ahead;
  logic [FW-1:0]        n_ext;
  logic [FW-1:0]        first_calc;
  logic                 dn_leaf;
  logic [FW-1:0]        cidx;
  logic [FW-1:0]        cidx_next;
  logic                 dn_take;
  logic signed [KW-1:0] dn_best;
  logic [AW-1:0]        dn_best_idx;
  logic                 dn_more;
  logic                 dn_move;

  assign in_ch.ready  = (state_r == thpq_pkg::S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign is_full    = (count_r == CW'(CAPACITY));
  assign is_empty   = (count_r == '0);
  assign new_parent = (state_r == thpq_pkg::S_IDLE)
                      ? AW'(thpq_pkg::div3(16'(count_r - CW'(1))))
                      : AW'(thpq_pkg::div3(16'(parent_r - AW'(1))));
  assign up_ahead   = ranks_ahead(key_r, mem_rdata, order_mode_r);

  assign n_ext       = FW'(count_r);
  assign first_calc  = FW'(pos_r) + (FW'(pos_r) << 1) + FW'(1);
  assign dn_leaf     = (first_calc >= n_ext);
  assign cidx        = first_r + FW'(csel_r);
  assign cidx_next   = cidx + FW'(1);
  assign dn_take     = (csel_r == 2'd0) || ranks_ahead(mem_rdata, best_r, order_mode_r);
  assign dn_best     = dn_take ? mem_rdata : best_r;
  assign dn_best_idx = dn_take ? AW'(cidx) : best_idx_r;
  assign dn_more     = (csel_r != 2'd2) && (cidx_next < n_ext);
  assign dn_move     = ranks_ahead(dn_best, key_r, order_mode_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      thpq_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.opcode)
            thpq_pkg::OP_INSERT: begin
              if (is_full || is_empty) state_nxt = thpq_pkg::S_DONE;
              else state_nxt = thpq_pkg::S_UP;
            end
            thpq_pkg::OP_REMOVE, thpq_pkg::OP_PEEK: begin
              if (is_empty) state_nxt = thpq_pkg::S_DONE;
              else state_nxt = thpq_pkg::S_RD_TOP;
            end
            default: state_nxt = thpq_pkg::S_DONE;
          endcase
        end
      end
      thpq_pkg::S_UP: begin
        if (!up_ahead) state_nxt = thpq_pkg::S_DONE;
        else if (parent_r == '0) state_nxt = thpq_pkg::S_FIN;
      end
      thpq_pkg::S_FIN: state_nxt = thpq_pkg::S_DONE;
      thpq_pkg::S_RD_TOP: begin
        if (op_r == thpq_pkg::OP_PEEK || count_r == CW'(1)) state_nxt = thpq_pkg::S_DONE;
        else state_nxt = thpq_pkg::S_RD_LAST;
      end
      thpq_pkg::S_RD_LAST: state_nxt = thpq_pkg::S_DN_START;
      thpq_pkg::S_DN_START: begin
        if (dn_leaf) state_nxt = thpq_pkg::S_DONE;
        else state_nxt = thpq_pkg::S_DN_CH;
      end
      thpq_pkg::S_DN_CH: begin
        if (!dn_more) begin
          if (dn_move) state_nxt = thpq_pkg::S_DN_START;
          else state_nxt = thpq_pkg::S_DONE;
        end
      end
      thpq_pkg::S_DONE: begin
        if (out_free) state_nxt = thpq_pkg::S_IDLE;
      end
      default: state_nxt = thpq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_nxt       = op_r;
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    parent_nxt   = parent_r;
    count_nxt    = count_r;
    first_nxt    = first_r;
    csel_nxt     = csel_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    top_nxt      = top_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = pos_r;
    mem_wdata    = key_r;
    mem_raddr    = '0;
    unique case (state_r)
      thpq_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_ch.opcode;
          key_nxt    = in_ch.key_value;
          top_nxt    = '0;
          status_nxt = thpq_pkg::STAT_OK;
          unique case (in_ch.opcode)
            thpq_pkg::OP_INSERT: begin
              if (is_full) begin
                status_nxt = thpq_pkg::STAT_FULL;
              end else begin
                count_nxt  = count_r + CW'(1);
                pos_nxt    = AW'(count_r);
                parent_nxt = new_parent;
                mem_raddr  = new_parent;
                // First key goes straight to the root
                if (is_empty) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = in_ch.key_value;
                end
              end
            end
            thpq_pkg::OP_REMOVE, thpq_pkg::OP_PEEK: begin
              if (is_empty) status_nxt = thpq_pkg::STAT_EMPTY;
            end
            default: ;
          endcase
        end
      end
      // Climb: pull the parent down while the new key outranks it
      thpq_pkg::S_UP: begin
        mem_we = 1'b1;
        if (up_ahead) begin
          mem_wdata  = mem_rdata;
          pos_nxt    = parent_r;
          parent_nxt = new_parent;
          mem_raddr  = new_parent;
        end
      end
      thpq_pkg::S_FIN: begin
        mem_we = 1'b1;
      end
      thpq_pkg::S_RD_TOP: begin
        top_nxt = mem_rdata;
        if (op_r == thpq_pkg::OP_REMOVE) begin
          count_nxt = count_r - CW'(1);
          mem_raddr = AW'(count_r - CW'(1));
        end
      end
      // Last entry becomes the key that sinks from the root
      thpq_pkg::S_RD_LAST: begin
        key_nxt = mem_rdata;
        pos_nxt = '0;
      end
      thpq_pkg::S_DN_START: begin
        if (dn_leaf) begin
          mem_we = 1'b1;
        end else begin
          first_nxt = first_calc;
          csel_nxt  = 2'd0;
          mem_raddr = AW'(first_calc);
        end
      end
      // Scan children one per cycle, lowest slot wins ties
      thpq_pkg::S_DN_CH: begin
        best_nxt     = dn_best;
        best_idx_nxt = dn_best_idx;
        if (dn_more) begin
          csel_nxt  = csel_r + 2'd1;
          mem_raddr = AW'(cidx_next);
        end else begin
          mem_we = 1'b1;
          if (dn_move) begin
            mem_wdata = dn_best;
            pos_nxt   = dn_best_idx;
          end
        end
      end
      thpq_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= thpq_pkg::S_IDLE;
      count_r      <= '0;
      order_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_ch.valid && cfg_ch.ready) order_mode_r <= cfg_ch.order_mode;
      if (state_r == thpq_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    parent_r   <= parent_nxt;
    first_r    <= first_nxt;
    csel_r     <= csel_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    if (state_r == thpq_pkg::S_DONE && out_free) begin
      out_top_r    <= top_r;
      out_status_r <= status_r;
      out_occ_r    <= thpq_pkg::OCC_W'(count_r);
    end
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= heap_mem[mem_raddr];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

endmodule
